// File: design/sorted_priority_queue_unit_defines.svh
// Assertion macros shared by the sorted priority queue checkers.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sorted priority queue check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sorted priority queue check failed");

`endif

// File: design/spq_pkg.sv
// Shared constants, types and helpers of the sorted priority queue.
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int ITEM_W      = 32;
  localparam int PRIO_W      = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [ITEM_W-1:0] TOP_EMPTY = '1;

  // One slot of the sorted chain.
  typedef struct packed {
    logic                     valid;
    logic [VALUE_WIDTH-1:0]   value;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

  // Broadcast to every cell in a cycle.
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } ctrl_t;

  function automatic logic [ITEM_W-1:0] sext_value(input logic [VALUE_WIDTH-1:0] v);
    return ITEM_W'($signed(v));
  endfunction

endpackage

// File: design/sorted_priority_queue_unit.sv
// Sorted priority queue: a chain of compare-and-shift slots behind a stream port.
//
// The queue holds up to QUEUE_DEPTH entries in a row of slots kept in
// descending priority order, slot 0 being the head. Every item on the input
// stream is either an insert (in_tuser = 0) carrying an item and its priority,
// or a remove (in_tuser = 1) that takes the head. An insert is placed behind
// every entry of greater or equal priority, so equal priorities leave first in,
// first out. Each item yields exactly one result item, registered as it is
// accepted: the popped entry and its valid flag, underflow for a remove from
// an empty queue, overflow for an insert into a full queue (that insert is
// dropped), the empty flag and the item now at the head (all ones when empty).
// Each slot compares the incoming priority against its own in parallel and
// shifts its neighbor's entry in, so one item is taken every cycle; the only
// stall is a result still waiting in the output register. Slot contents come
// up undefined after reset, only their valid bits are cleared, so there is no
// clearing pass and the queue is ready as soon as reset is released.
module sorted_priority_queue_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] item_value, [63:32] item_priority
  input  logic [0:0]  in_tuser,   // [0] op
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // [31:0] popped_value, [63:32] popped_priority,
                                  // [95:64] top_value
  output logic [3:0]  out_tuser   // [0] popped_valid, [1] underflow, [2] overflow,
                                  // [3] is_empty
);

  localparam int DEPTH = spq_pkg::QUEUE_DEPTH;

  spq_pkg::ctrl_t  ctrl;
  spq_pkg::entry_t cell_ent [DEPTH];
  spq_pkg::entry_t cell_nxt [DEPTH];
  logic            cell_take[DEPTH];

  logic        accept;
  logic        is_insert;
  logic        is_remove;
  logic        full;
  logic        head_valid;

  logic        out_valid_r;
  logic [95:0] out_tdata_r;
  logic [3:0]  out_tuser_r;
  logic [95:0] res_tdata;
  logic [3:0]  res_tuser;

  // Advance whenever the output register is free or being drained.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign is_insert  = (in_tuser[0] == spq_pkg::OP_INSERT);
  assign is_remove  = (in_tuser[0] == spq_pkg::OP_REMOVE);
  assign full       = cell_ent[DEPTH-1].valid;
  assign head_valid = cell_ent[0].valid;

  // Drop an insert into a full queue and a remove from an empty one.
  assign ctrl.ins             = accept && is_insert && !full;
  assign ctrl.rem             = accept && is_remove && head_valid;
  assign ctrl.new_entry.valid = 1'b1;
  assign ctrl.new_entry.value = in_tdata[spq_pkg::VALUE_WIDTH-1:0];
  assign ctrl.new_entry.prio  = in_tdata[63:32];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_ent;
    spq_pkg::entry_t right_ent;
    logic            left_take;

    if (i == 0) begin : g_head
      assign left_ent  = '0;
      assign left_take = 1'b0;
    end else begin : g_body
      assign left_ent  = cell_ent[i-1];
      assign left_take = cell_take[i-1];
    end

    // The tail refills with an empty slot on a remove.
    if (i == DEPTH-1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_link
      assign right_ent = cell_ent[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .left_take (left_take),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .ent       (cell_ent[i]),
      .ent_nxt   (cell_nxt[i]),
      .take      (cell_take[i])
    );
  end

  // Result: popped entry from the current head, status from the head after
  // this item.
  always_comb begin
    res_tdata = '0;
    res_tuser = '0;
    if (ctrl.rem) begin
      res_tdata[31:0]  = spq_pkg::sext_value(cell_ent[0].value);
      res_tdata[63:32] = cell_ent[0].prio;
      res_tuser[0]     = 1'b1;
    end
    res_tuser[1] = is_remove && !head_valid;
    res_tuser[2] = is_insert && full;
    res_tuser[3] = !cell_nxt[0].valid;
    res_tdata[95:64] = cell_nxt[0].valid ? spq_pkg::sext_value(cell_nxt[0].value)
                                         : spq_pkg::TOP_EMPTY;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (accept) begin
      out_tdata_r <= res_tdata;
      out_tuser_r <= res_tuser;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// File: design/spq_cell.sv
// One slot of the sorted shift chain: compare, hold, shift down or shift up.
module spq_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  spq_pkg::ctrl_t  ctrl,
  input  logic            left_take,
  input  spq_pkg::entry_t left_ent,
  input  spq_pkg::entry_t right_ent,
  output spq_pkg::entry_t ent,
  output spq_pkg::entry_t ent_nxt,
  output logic            take
);

  logic                              valid_r;
  logic [spq_pkg::VALUE_WIDTH-1:0]   value_r;
  logic signed [spq_pkg::PRIO_W-1:0] prio_r;

  assign ent.valid = valid_r;
  assign ent.value = value_r;
  assign ent.prio  = prio_r;

  // New entry belongs here or earlier: slot free or strictly lower priority,
  // so equal priorities stay first in, first out.
  assign take = ctrl.ins && (!valid_r || (ctrl.new_entry.prio > prio_r));

  always_comb begin
    ent_nxt = ent;
    if (ctrl.rem) begin
      ent_nxt = right_ent;
    end else if (take) begin
      ent_nxt = left_take ? left_ent : ctrl.new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ent_nxt.valid;
    end
    value_r <= ent_nxt.value;
    prio_r  <= ent_nxt.prio;
  end

endmodule

// File: design/spq_checker.sv
// Port-level checks of the sorted priority queue, bound to the top level.
`include "sorted_priority_queue_unit_defines.svh"

module spq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic [3:0]  out_tuser
);

  // A remove either returns an entry or underflows, never both.
  `SPQ_ASSERT_NOW(a_pop_xor_under, clk, rst_n, out_tvalid, !(out_tuser[0] && out_tuser[1]))

  // A dropped insert means the queue was full, so it cannot read empty.
  `SPQ_ASSERT_NOW(a_over_not_empty, clk, rst_n, out_tvalid && out_tuser[2], !out_tuser[3])

  // An empty queue reports all ones as its head item.
  `SPQ_ASSERT_NOW(a_empty_top, clk, rst_n, out_tvalid && out_tuser[3], &out_tdata[95:64])

  // No popped entry means zero pop fields.
  `SPQ_ASSERT_NOW(a_pop_zero, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata[63:0] == 64'd0)

  // A stalled result holds.
  `SPQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
